>>> design/integer_to_text_in_base_defines.svh
// assertion macros shared by the integer_to_text_in_base design files
// expects i_clk and i_rst_n in the scope of the module that uses them
`ifndef INTEGER_TO_TEXT_IN_BASE_DEFINES_SVH
`define INTEGER_TO_TEXT_IN_BASE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define ITB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ITB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/itb_pkg.sv
// shared types and constants for the integer to text converter
// used by itb_ctrl, itb_dp and the top level; no dependencies
package itb_pkg;

    localparam int DIV_CHUNKS = 8;
    localparam int CHUNK_BITS = 8;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SMALL = 2'd1;
    localparam logic [1:0] ST_BASE  = 2'd2;

    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [4:0] HEX_BASE = 5'd16;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_NEXT,
        S_BAD_BASE,
        S_SMALL,
        S_MINUS,
        S_ZERO,
        S_X,
        S_RD,
        S_DIG
    } t_itb_state;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_MINUS,
        EM_ZERO,
        EM_X,
        EM_DIGIT,
        EM_SMALL,
        EM_BASE
    } t_itb_emit;

    typedef struct packed {
        logic      load;
        logic      div_step;
        logic      rd_init;
        logic      rd_issue;
        t_itb_emit emit;
    } t_itb_cmd;

    typedef struct packed {
        logic out_free;
        logic step_last;
        logic div_zero;
        logic count_full;
        logic fits;
        logic neg;
        logic hex;
        logic digits_left;
        logic base_bad;
    } t_itb_stat;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        case (d)
            4'd0:    c = 8'h30;
            4'd1:    c = 8'h31;
            4'd2:    c = 8'h32;
            4'd3:    c = 8'h33;
            4'd4:    c = 8'h34;
            4'd5:    c = 8'h35;
            4'd6:    c = 8'h36;
            4'd7:    c = 8'h37;
            4'd8:    c = 8'h38;
            4'd9:    c = 8'h39;
            4'd10:   c = 8'h61;
            4'd11:   c = 8'h62;
            4'd12:   c = 8'h63;
            4'd13:   c = 8'h64;
            4'd14:   c = 8'h65;
            default: c = 8'h66;
        endcase
        return c;
    endfunction

endpackage

>>> design/itb_ram.sv
// generic single-write, single-read RAM with registered read data
// no dependencies
module itb_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic                                          i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/itb_ctrl.sv
// sequencing state machine for the integer to text converter
// depends on itb_pkg and integer_to_text_in_base_defines.svh
`include "integer_to_text_in_base_defines.svh"

module itb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  itb_pkg::t_itb_stat i_stat,
    output itb_pkg::t_itb_cmd  o_cmd
);
    import itb_pkg::*;

    t_itb_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_in_ready     = 1'b0;
        o_cmd.load     = 1'b0;
        o_cmd.div_step = 1'b0;
        o_cmd.rd_init  = 1'b0;
        o_cmd.rd_issue = 1'b0;
        o_cmd.emit     = EM_NONE;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.base_bad ? S_BAD_BASE : S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.step_last) begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                o_cmd.rd_init = 1'b1;
                if (!i_stat.div_zero && !i_stat.count_full) begin
                    n_state = S_DIV;
                end else if (!i_stat.div_zero || !i_stat.fits) begin
                    n_state = S_SMALL;
                end else if (i_stat.neg) begin
                    n_state = S_MINUS;
                end else if (i_stat.hex) begin
                    n_state = S_ZERO;
                end else begin
                    n_state = S_RD;
                end
            end
            S_BAD_BASE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = EM_BASE;
                    n_state    = S_IDLE;
                end
            end
            S_SMALL: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = EM_SMALL;
                    n_state    = S_IDLE;
                end
            end
            S_MINUS: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = EM_MINUS;
                    n_state    = i_stat.hex ? S_ZERO : S_RD;
                end
            end
            S_ZERO: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = EM_ZERO;
                    n_state    = S_X;
                end
            end
            S_X: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = EM_X;
                    n_state    = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_DIG;
            end
            S_DIG: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = EM_DIGIT;
                    n_state    = i_stat.digits_left ? S_RD : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // a stored digit must remain whenever a read is issued
    `ITB_ASSERT_IMP(a_rd_has_digit, r_state == S_RD, i_stat.digits_left,
                    "digit read issued with no digit left")
    // a full digit store ends the division
    `ITB_ASSERT_NXT(a_full_stops_div, (r_state == S_NEXT) && i_stat.count_full,
                    r_state != S_DIV, "division continued past a full digit store")

endmodule

>>> design/itb_dp.sv
// datapath: chunked digit division, digit store, text assembly, output register
// depends on itb_pkg, itb_ram and integer_to_text_in_base_defines.svh
`include "integer_to_text_in_base_defines.svh"

module itb_dp #(
    parameter int MAX_CHARS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic signed [63:0] i_number,
    input  logic [4:0]         i_radix,
    input  logic [6:0]         i_room,
    input  itb_pkg::t_itb_cmd  i_cmd,
    output itb_pkg::t_itb_stat o_stat,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_out_char,
    output logic [5:0]         o_char_pos,
    output logic               o_is_last,
    output logic [1:0]         o_status,
    output logic [6:0]         o_text_len
);
    import itb_pkg::*;

    localparam int CW = $clog2(MAX_CHARS + 1);
    localparam int AW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
    localparam int PW = (CW + 2 > 7) ? CW + 2 : 7;

    logic [63:0]   r_div, n_div;
    logic [3:0]    r_rem, n_rem;
    logic [4:0]    r_base;
    logic          r_neg;
    logic          r_hex;
    logic [CW-1:0] r_cap;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_rd_idx;
    logic [2:0]    r_step;
    logic [PW-1:0] r_pos;

    logic          r_out_valid;
    logic [7:0]    r_out_char;
    logic [PW-1:0] r_out_pos;
    logic          r_out_last;
    logic [1:0]    r_out_status;
    logic [PW-1:0] r_out_len;

    logic [63:0]   mag;
    logic [CW-1:0] cap_in;
    logic [PW-1:0] total;
    logic [PW-1:0] pos_inc;
    logic [CW-1:0] rd_prev;
    logic          step_last;
    logic          ram_we;
    logic [3:0]    ram_q;
    logic [CHUNK_BITS-1:0] q_bits;
    logic [4:0]    trial;
    logic [7:0]    em_char;

    assign mag    = i_number[63] ? (~i_number + 64'd1) : i_number;
    assign cap_in = ({1'b0, i_room} > 8'(MAX_CHARS)) ? CW'(MAX_CHARS) : CW'(i_room);
    assign total  = PW'(r_count) + PW'(r_neg) + (r_hex ? PW'(2) : '0);
    assign pos_inc = r_pos + PW'(1);
    assign rd_prev = r_rd_idx - CW'(1);
    assign step_last = (r_step == 3'(DIV_CHUNKS - 1));
    assign ram_we    = i_cmd.div_step && step_last;

    // eight restoring steps per cycle on the top byte of the dividend
    always_comb begin
        n_rem  = r_rem;
        q_bits = '0;
        trial  = '0;
        for (int k = 0; k < CHUNK_BITS; k++) begin
            trial = {n_rem, r_div[63-k]};
            if (trial >= r_base) begin
                trial = trial - r_base;
                q_bits[CHUNK_BITS-1-k] = 1'b1;
            end
            n_rem = trial[3:0];
        end
        n_div = {r_div[63-CHUNK_BITS:0], q_bits};
    end

    itb_ram #(
        .WIDTH (4),
        .DEPTH (MAX_CHARS)
    ) u_digits (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (n_rem),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (rd_prev[AW-1:0]),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_count <= '0;
            r_div   <= '0;
        end else if (i_cmd.load) begin
            r_step  <= '0;
            r_count <= '0;
            r_div   <= mag;
        end else if (i_cmd.div_step) begin
            r_step <= r_step + 3'd1;
            r_div  <= n_div;
            if (step_last) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem  <= '0;
            r_base <= i_radix;
            r_neg  <= i_number[63];
            r_hex  <= (i_radix == HEX_BASE);
            r_cap  <= cap_in;
            r_pos  <= '0;
        end else begin
            if (i_cmd.div_step) begin
                r_rem <= step_last ? 4'd0 : n_rem;
            end
            if (i_cmd.emit != EM_NONE) begin
                r_pos <= pos_inc;
            end
        end
        if (i_cmd.rd_init) begin
            r_rd_idx <= r_count;
        end else if (i_cmd.rd_issue) begin
            r_rd_idx <= rd_prev;
        end
    end

    always_comb begin
        case (i_cmd.emit)
            EM_MINUS: em_char = CH_MINUS;
            EM_ZERO:  em_char = CH_ZERO;
            EM_X:     em_char = CH_X;
            EM_DIGIT: em_char = digit_char(ram_q);
            default:  em_char = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit != EM_NONE) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit == EM_SMALL || i_cmd.emit == EM_BASE) begin
            r_out_char   <= 8'd0;
            r_out_pos    <= '0;
            r_out_last   <= 1'b1;
            r_out_status <= (i_cmd.emit == EM_BASE) ? ST_BASE : ST_SMALL;
            r_out_len    <= '0;
        end else if (i_cmd.emit != EM_NONE) begin
            r_out_char   <= em_char;
            r_out_pos    <= r_pos;
            r_out_last   <= (pos_inc == total);
            r_out_status <= ST_OK;
            r_out_len    <= total;
        end
    end

    assign o_stat.out_free    = !r_out_valid || i_out_ready;
    assign o_stat.step_last   = step_last;
    assign o_stat.div_zero    = (r_div == 64'd0);
    assign o_stat.count_full  = (r_count == CW'(MAX_CHARS));
    assign o_stat.fits        = (total <= PW'(r_cap));
    assign o_stat.neg         = r_neg;
    assign o_stat.hex         = r_hex;
    assign o_stat.digits_left = (r_rd_idx != '0);
    assign o_stat.base_bad    = (i_radix == 5'd0) || (i_radix > HEX_BASE);

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_char_pos  = r_out_pos[5:0];
    assign o_is_last   = r_out_last;
    assign o_status    = r_out_status;
    assign o_text_len  = r_out_len[6:0];

    // a new beat is never loaded over one that is still waiting
    `ITB_ASSERT_IMP(a_emit_free, i_cmd.emit != EM_NONE, !r_out_valid || i_out_ready,
                    "output register overwritten while stalled")
    // digits never land beyond the store
    `ITB_ASSERT_IMP(a_wr_in_range, ram_we, r_count < CW'(MAX_CHARS),
                    "digit written past the end of the store")
    // the final character of good text sits at length minus one
    `ITB_ASSERT_IMP(a_last_pos, r_out_valid && r_out_last && (r_out_status == ST_OK),
                    r_out_len == r_out_pos + PW'(1), "last character at the wrong position")

endmodule

>>> design/integer_to_text_in_base.sv
// integer_to_text_in_base: signed 64-bit integer to ASCII text in base 1 to 16
// ports: one input channel (number, radix, room) and one output channel, one
// beat per character, both valid/ready; a beat moves when valid and ready are high.
// the text is '-' for negative values, "0x" for base 16, then lowercase digits,
// most significant first; is_last marks the final beat of a conversion.
// a base of 0 or above 16 gives one beat with status 2; text longer than
// min(room, MAX_CHARS) gives one beat with status 1; both carry length 0.
// one conversion at a time: in_ready is high only while the block is idle.
// each digit takes a full pass of the divider over the 64-bit dividend (8 bits of the
// dividend per cycle, in S_DIV) plus a check in S_NEXT; all digits are stored before
// the first beat, and each digit beat waits on a digit store read (S_RD).
// a stalled receiver holds the output register and the sequencer waits on it;
// no beat is lost or repeated.
// reset (synchronous, active low) returns to idle and drops out_valid; the digit
// store needs no clearing.
// depends on itb_pkg, itb_ctrl, itb_dp and itb_ram
module integer_to_text_in_base #(
    parameter int MAX_CHARS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [63:0] i_number,
    input  logic [4:0]         i_radix,
    input  logic [6:0]         i_room,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_out_char,
    output logic [5:0]         o_char_pos,
    output logic               o_is_last,
    output logic [1:0]         o_status,
    output logic [6:0]         o_text_len
);
    import itb_pkg::*;

    t_itb_cmd  cmd;
    t_itb_stat stat;

    itb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    itb_dp #(
        .MAX_CHARS (MAX_CHARS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_number    (i_number),
        .i_radix     (i_radix),
        .i_room      (i_room),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_char  (o_out_char),
        .o_char_pos  (o_char_pos),
        .o_is_last   (o_is_last),
        .o_status    (o_status),
        .o_text_len  (o_text_len)
    );

endmodule
